// ===== rtl/core/fwsc_pkg.sv =====
// ----------------------------------------------------------------------------
// fwsc_pkg: shared types and constants for the four-way sequence coverage table
// Request and result payloads, configuration bundle, sequencer states and the
// table of distinct ordered 4-tuple counts per event count.
// ----------------------------------------------------------------------------
package fwsc_pkg;

	// Fixed field geometry
	localparam int ORDER_W      = 64;
	localparam int NIB_W        = 4;
	localparam int EVENT_VALS   = 2 ** NIB_W;
	localparam int NUM_EVENTS_W = 5;
	localparam int UNCOV_W      = 11;
	localparam int TOTAL_W      = 16;

	// Default event limit and derived map geometry
	localparam int MAX_EVENTS_DEF = 16;
	localparam int EV_W_DEF       = $clog2(MAX_EVENTS_DEF);

	// Register port
	localparam int DATA_W    = 32;
	localparam int ADDR_W    = 3;
	localparam int REG_IDX_W = ADDR_W - 2;
	localparam logic [REG_IDX_W-1:0] REG_NUM_EVENTS = '0;

	localparam logic [NUM_EVENTS_W-1:0] NUM_EVENTS_RST = 5'd16;
	localparam logic [NUM_EVENTS_W-1:0] MIN_EVENTS     = 5'd4;

	// Request kinds
	localparam logic REQ_SCORE = 1'b0;
	localparam logic REQ_MARK  = 1'b1;

	typedef struct packed {
		logic               req_type;
		logic [ORDER_W-1:0] order;
	} req_t;

	typedef struct packed {
		logic [UNCOV_W-1:0] uncovered_count;
		logic [TOTAL_W-1:0] covered_total;
		logic               full_cover;
		logic               order_error;
	} res_t;

	// Register block to engine
	typedef struct packed {
		logic                    clear_req;
		logic [NUM_EVENTS_W-1:0] num_events;
	} cfg_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CHECK,
		ST_RUN,
		ST_DRAIN,
		ST_DONE
	} state_t;

	// n*(n-1)*(n-2)*(n-3) for the legal event counts
	function automatic logic [TOTAL_W-1:0] tuple_total(input logic [NUM_EVENTS_W-1:0] n);
		logic [TOTAL_W-1:0] t;
		case (n)
			5'd4:    t = 16'd24;
			5'd5:    t = 16'd120;
			5'd6:    t = 16'd360;
			5'd7:    t = 16'd840;
			5'd8:    t = 16'd1680;
			5'd9:    t = 16'd3024;
			5'd10:   t = 16'd5040;
			5'd11:   t = 16'd7920;
			5'd12:   t = 16'd11880;
			5'd13:   t = 16'd17160;
			5'd14:   t = 16'd24024;
			5'd15:   t = 16'd32760;
			5'd16:   t = 16'd43680;
			default: t = '0;
		endcase
		return t;
	endfunction

endpackage

// ===== rtl/core/fwsc_regs.sv =====
// ----------------------------------------------------------------------------
// fwsc_regs: configuration register file
// Holds the event count; any write to it asks the engine for a new coverage run.
// ----------------------------------------------------------------------------
module fwsc_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [fwsc_pkg::ADDR_W-1:0]  paddr,
	input  logic [fwsc_pkg::DATA_W-1:0]  pwdata,
	output logic [fwsc_pkg::DATA_W-1:0]  prdata,
	output logic                         pready,
	output fwsc_pkg::cfg_t               cfg
);
	import fwsc_pkg::*;

	logic [REG_IDX_W-1:0]    reg_idx;
	logic                    wr_hit;
	logic [NUM_EVENTS_W-1:0] num_events_q;

	assign reg_idx = paddr[ADDR_W-1:2];
	assign pready  = 1'b1;
	assign wr_hit  = psel & penable & pwrite & pready & (reg_idx == REG_NUM_EVENTS);

	// Event count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_events_q <= NUM_EVENTS_RST;
		end else if (wr_hit) begin
			num_events_q <= pwdata[NUM_EVENTS_W-1:0];
		end
	end

	// Read mux
	always_comb begin
		prdata = '0;
		if (reg_idx == REG_NUM_EVENTS) begin
			prdata = {{(DATA_W-NUM_EVENTS_W){1'b0}}, num_events_q};
		end
	end

	assign cfg.clear_req  = wr_hit;
	assign cfg.num_events = num_events_q;

endmodule

// ===== rtl/core/fwsc_map.sv =====
// ----------------------------------------------------------------------------
// fwsc_map: coverage bit map
// One row per (a,b,c) event prefix, one bit per last event d. Single write
// port, single read port, registered read data.
// ----------------------------------------------------------------------------
module fwsc_map #(
	parameter int ROW_AW = 3 * fwsc_pkg::EV_W_DEF,
	parameter int ROW_W  = 2 ** fwsc_pkg::EV_W_DEF
) (
	input  logic              clk,
	input  logic              rd_en,
	input  logic [ROW_AW-1:0] rd_addr,
	output logic [ROW_W-1:0]  rd_data,
	input  logic              wr_en,
	input  logic [ROW_AW-1:0] wr_addr,
	input  logic [ROW_W-1:0]  wr_data
);
	logic [ROW_W-1:0] mem [2**ROW_AW];
	logic [ROW_W-1:0] rd_data_q;

	// Read returns the contents before a same-edge write
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== rtl/core/fwsc_engine.sv =====
// ----------------------------------------------------------------------------
// fwsc_engine: request sequencer and map read-modify-write
// Validates the order, walks every 4-subsequence one per cycle, tests map bits,
// sets them for mark requests with one-deep write forwarding, and sweeps the map clear on demand.
// ----------------------------------------------------------------------------
module fwsc_engine #(
	parameter int MAX_EVENTS = fwsc_pkg::MAX_EVENTS_DEF,
	localparam int EV_W      = $clog2(MAX_EVENTS),
	localparam int ROW_AW    = 3 * EV_W,
	localparam int ROW_W     = 2 ** EV_W
) (
	input  logic              clk,
	input  logic              arst_n,
	input  fwsc_pkg::cfg_t    cfg,
	input  logic              req_valid,
	output logic              req_ready,
	input  fwsc_pkg::req_t    req_data,
	output logic              res_valid,
	input  logic              res_ready,
	output fwsc_pkg::res_t    res_data,
	output logic              rd_en,
	output logic [ROW_AW-1:0] rd_addr,
	input  logic [ROW_W-1:0]  rd_data,
	output logic              wr_en,
	output logic [ROW_AW-1:0] wr_addr,
	output logic [ROW_W-1:0]  wr_data
);
	import fwsc_pkg::*;

	localparam int POS_W = $clog2(MAX_EVENTS);
	localparam logic [NUM_EVENTS_W-1:0] MAX_N = NUM_EVENTS_W'(MAX_EVENTS);

	state_t state_q, state_d;

	logic [NUM_EVENTS_W-1:0]              n, n_m1, n_m2, n_m3, n_m4;
	logic [MAX_EVENTS-1:0][NIB_W-1:0]     ev_q;
	logic                                 mark_q;
	logic                                 err_q;
	logic [POS_W-1:0]                     i_q, j_q, k_q, r_q;
	logic                                 i_end, j_end, k_end, r_end, last_tuple;
	logic [ROW_AW-1:0]                    clr_cnt_q;
	logic [UNCOV_W-1:0]                   uncov_cnt_q;
	logic [TOTAL_W-1:0]                   covered_cnt_q;
	logic                                 bad;
	logic [EVENT_VALS-1:0]                seen, want;
	logic                                 accept, load_res;

	// Map pipeline
	logic                                 valid_s1;
	logic [ROW_AW-1:0]                    row_s1;
	logic [EV_W-1:0]                      bit_s1;
	logic                                 wr_valid_q;
	logic [ROW_AW-1:0]                    wr_addr_q;
	logic [ROW_W-1:0]                     wr_row_q;
	logic [ROW_W-1:0]                     row_cur;
	logic                                 fresh, mark_wr;

	res_t res_q;
	logic res_valid_q;

	// Effective event count, saturated to the legal range
	always_comb begin
		if (cfg.num_events < MIN_EVENTS) begin
			n = MIN_EVENTS;
		end else if (cfg.num_events > MAX_N) begin
			n = MAX_N;
		end else begin
			n = cfg.num_events;
		end
	end

	assign n_m1 = n - NUM_EVENTS_W'(1);
	assign n_m2 = n - NUM_EVENTS_W'(2);
	assign n_m3 = n - NUM_EVENTS_W'(3);
	assign n_m4 = n - NUM_EVENTS_W'(4);

	// Order check: every used event below n and no repeats
	always_comb begin
		bad  = 1'b0;
		seen = '0;
		for (int p = 0; p < MAX_EVENTS; p++) begin
			if (NUM_EVENTS_W'(p) < n) begin
				if ({1'b0, ev_q[p]} >= n) begin
					bad = 1'b1;
				end
				seen = seen | (EVENT_VALS'(1) << ev_q[p]);
			end
		end
		for (int v = 0; v < EVENT_VALS; v++) begin
			want[v] = (NUM_EVENTS_W'(v) < n);
		end
		if (seen != want) begin
			bad = 1'b1;
		end
	end

	// Subsequence position ends
	assign r_end      = (NUM_EVENTS_W'(r_q) == n_m1);
	assign k_end      = (NUM_EVENTS_W'(k_q) == n_m2);
	assign j_end      = (NUM_EVENTS_W'(j_q) == n_m3);
	assign i_end      = (NUM_EVENTS_W'(i_q) == n_m4);
	assign last_tuple = r_end & k_end & j_end & i_end;

	assign accept    = req_valid & req_ready;
	assign req_ready = (state_q == ST_IDLE);
	assign load_res  = (state_q == ST_DONE) & (~res_valid_q | res_ready);

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_cnt_q == '1) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (req_valid) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				state_d = bad ? ST_DONE : ST_RUN;
			end
			ST_RUN: begin
				if (last_tuple) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (load_res) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		if (cfg.clear_req) begin
			state_d = ST_CLEAR;
		end
	end

	// Request capture and error flag
	always_ff @(posedge clk) begin
		if (accept) begin
			for (int p = 0; p < MAX_EVENTS; p++) begin
				ev_q[p] <= req_data.order[p*NIB_W +: NIB_W];
			end
			mark_q <= (req_data.req_type == REQ_MARK);
			err_q  <= 1'b0;
		end else if (state_q == ST_CHECK) begin
			err_q <= bad;
		end
	end

	// Position counters i < j < k < r
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q <= '0;
			j_q <= '0;
			k_q <= '0;
			r_q <= '0;
		end else if (state_q == ST_CHECK) begin
			i_q <= POS_W'(0);
			j_q <= POS_W'(1);
			k_q <= POS_W'(2);
			r_q <= POS_W'(3);
		end else if (state_q == ST_RUN) begin
			if (!r_end) begin
				r_q <= r_q + POS_W'(1);
			end else if (!k_end) begin
				k_q <= k_q + POS_W'(1);
				r_q <= k_q + POS_W'(2);
			end else if (!j_end) begin
				j_q <= j_q + POS_W'(1);
				k_q <= j_q + POS_W'(2);
				r_q <= j_q + POS_W'(3);
			end else if (!i_end) begin
				i_q <= i_q + POS_W'(1);
				j_q <= i_q + POS_W'(2);
				k_q <= i_q + POS_W'(3);
				r_q <= i_q + POS_W'(4);
			end
		end
	end

	// Map read: row from the first three events, bit from the fourth
	assign rd_en   = (state_q == ST_RUN);
	assign rd_addr = {ev_q[i_q][EV_W-1:0], ev_q[j_q][EV_W-1:0], ev_q[k_q][EV_W-1:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= rd_en;
		end
	end

	always_ff @(posedge clk) begin
		row_s1 <= rd_addr;
		bit_s1 <= ev_q[r_q][EV_W-1:0];
	end

	// Forward the row written at the read edge
	assign row_cur = (wr_valid_q && (wr_addr_q == row_s1)) ? wr_row_q : rd_data;
	assign fresh   = valid_s1 & ~row_cur[bit_s1];
	assign mark_wr = fresh & mark_q;

	// Write port: clearing sweep or bit set
	always_comb begin
		if (state_q == ST_CLEAR) begin
			wr_en   = 1'b1;
			wr_addr = clr_cnt_q;
			wr_data = '0;
		end else begin
			wr_en   = mark_wr;
			wr_addr = row_s1;
			wr_data = row_cur | (ROW_W'(1) << bit_s1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_valid_q <= 1'b0;
		end else begin
			wr_valid_q <= wr_en;
		end
	end

	always_ff @(posedge clk) begin
		wr_addr_q <= wr_addr;
		wr_row_q  <= wr_data;
	end

	// Clear sweep row counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cfg.clear_req) begin
			clr_cnt_q <= '0;
		end else if (state_q == ST_CLEAR) begin
			clr_cnt_q <= clr_cnt_q + ROW_AW'(1);
		end
	end

	// Per-request and running counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			uncov_cnt_q   <= '0;
			covered_cnt_q <= '0;
		end else begin
			if (accept) begin
				uncov_cnt_q <= '0;
			end else if (fresh) begin
				uncov_cnt_q <= uncov_cnt_q + UNCOV_W'(1);
			end
			if (cfg.clear_req) begin
				covered_cnt_q <= '0;
			end else if (mark_wr) begin
				covered_cnt_q <= covered_cnt_q + TOTAL_W'(1);
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load_res) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_res) begin
			res_q.uncovered_count <= uncov_cnt_q;
			res_q.covered_total   <= covered_cnt_q;
			res_q.full_cover      <= (covered_cnt_q >= tuple_total(n));
			res_q.order_error     <= err_q;
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

endmodule

// ===== rtl/core/four_way_sequence_coverage_table.sv =====
// ----------------------------------------------------------------------------
// four_way_sequence_coverage_table: coverage map over ordered event 4-tuples
// Scores or marks test orders against a map of covered 4-subsequences.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid/req_ready/req_data) takes one test order and a
//   score or mark kind. Result channel (res_valid/res_ready/res_data) returns
//   the uncovered subsequence count, running covered total, all-covered flag
//   and an order error flag. The register port holds the event count n.
// Sequencing:
//   A valid order passes from the check state through the run state, which
//   walks every 4-subsequence, and the drain state to the done state, where
//   the result register is loaded; a bad order goes from check straight to
//   done. One subsequence per cycle goes through the single map read port.
//   The next request is taken only in the idle state. Only one request is in
//   flight; req_ready rises again once its result is loaded.
// Reset and clearing:
//   After reset, and after any write of the event count, the map is swept
//   clear one row per cycle over all 2^(3*clog2(MAX_EVENTS)) rows, 4096 at 16
//   events. req_ready stays low during the sweep.
// Stalls:
//   A held result stays in the output register; a finished request waits for
//   the register to free before the next request is taken.
// ----------------------------------------------------------------------------
module four_way_sequence_coverage_table #(
	parameter int MAX_EVENTS = fwsc_pkg::MAX_EVENTS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [fwsc_pkg::ADDR_W-1:0]  paddr,
	input  logic [fwsc_pkg::DATA_W-1:0]  pwdata,
	output logic [fwsc_pkg::DATA_W-1:0]  prdata,
	output logic                         pready,
	input  logic                         req_valid,
	output logic                         req_ready,
	input  fwsc_pkg::req_t               req_data,
	output logic                         res_valid,
	input  logic                         res_ready,
	output fwsc_pkg::res_t               res_data
);
	import fwsc_pkg::*;

	localparam int EV_W   = $clog2(MAX_EVENTS);
	localparam int ROW_AW = 3 * EV_W;
	localparam int ROW_W  = 2 ** EV_W;

	cfg_t              cfg;
	logic              rd_en;
	logic [ROW_AW-1:0] rd_addr;
	logic [ROW_W-1:0]  rd_data;
	logic              wr_en;
	logic [ROW_AW-1:0] wr_addr;
	logic [ROW_W-1:0]  wr_data;

	fwsc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	fwsc_map #(
		.ROW_AW (ROW_AW),
		.ROW_W  (ROW_W)
	) u_map (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	fwsc_engine #(
		.MAX_EVENTS (MAX_EVENTS)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_data  (req_data),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_data  (res_data),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data)
	);

	// One request in flight at a time
	a_single_request: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while another is in flight");

	// A rejected order reports no uncovered subsequences
	a_error_no_count: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.order_error |-> res_data.uncovered_count == '0)
		else $error("order error with nonzero uncovered count");

	// An event count write starts a clearing sweep that blocks requests
	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		cfg.clear_req |=> !req_ready)
		else $error("request side open right after event count write");

endmodule
